FILE: hw/rtl/mmjd_pkg.sv
// shared types, constants and sequencer codes for the masked mean joint distance block
`default_nettype none

package mmjd_pkg;

  // joints per set that are accumulated; later pairs are skipped
  localparam int MAX_JOINTS = 64;
  localparam int PIDX_W     = $clog2(MAX_JOINTS + 1);

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 7;
  localparam int MEAN_W  = 30;

  localparam logic [MEAN_W-1:0] SENTINEL_Q16 = MEAN_W'(655360000);
  localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX      = '1;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      last_joint;
  } in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_distance;
    logic              no_overlap;
  } out_t;

  // shared compare-subtract unit result
  typedef struct packed {
    logic [SQ_W-1:0] diff;
    logic            ge;
  } alu_res_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DIV  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mmjd_alu.sv
// shared compare and subtract unit for square root and divide steps
`default_nettype none

module mmjd_alu (
  input  wire logic [mmjd_pkg::SQ_W-1:0] a,
  input  wire logic [mmjd_pkg::SQ_W-1:0] b,
  output mmjd_pkg::alu_res_t             res
);

  logic [mmjd_pkg::SQ_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign res  = '{diff: wide[mmjd_pkg::SQ_W-1:0], ge: ~wide[mmjd_pkg::SQ_W]};

endmodule

`default_nettype wire

FILE: hw/rtl/masked_mean_joint_distance_top.sv
// top level: masked mean joint distance over a set of joint-pair words
// a counted pair keeps busy high through the multiply, square root and accumulate states;
//   skipped non-last pairs and empty-skeleton words leave busy low
// a last pair with a nonzero count adds the divide state; the result strobe is registered,
//   and a new pair is taken only once busy has dropped after the previous one
// reset (synchronous, active low) clears sum, count, pair index and the sequencer
`default_nettype none

module masked_mean_joint_distance_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire mmjd_pkg::in_t in_word,
  output logic               out_valid,
  output mmjd_pkg::out_t     out_word
);

  localparam int SQ_W   = mmjd_pkg::SQ_W;
  localparam int SUM_W  = mmjd_pkg::SUM_W;
  localparam int CNT_W  = mmjd_pkg::CNT_W;
  localparam int PIDX_W = mmjd_pkg::PIDX_W;
  localparam int DIFF_W = mmjd_pkg::DIFF_W;

  // sequencer and accumulated set state
  mmjd_pkg::state_t state_r, state_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [PIDX_W-1:0] pidx_r, pidx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              last_r, last_nxt;

  // per-pair datapath
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [SQ_W-2:0]          prod_r, prod_nxt;
  logic [SQ_W-1:0]          rem_r, rem_nxt;     // sum of squares, then sqrt remainder
  logic [SQ_W-1:0]          root_r, root_nxt;
  logic [SQ_W-1:0]          bit_r, bit_nxt;

  // divide datapath
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] drem_r, drem_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  mmjd_pkg::out_t out_word_r, out_word_nxt;

  // shared unit hookup
  logic [SQ_W-1:0]    alu_a, alu_b;
  mmjd_pkg::alu_res_t alu_res;

  // multiplier operand select and product
  logic signed [DIFF_W-1:0] mul_sel;
  logic signed [SQ_W-1:0]   mul_full;

  logic accept, zero_a, zero_b, in_range;
  logic [SUM_W:0] sum_wide;
  logic [CNT_W:0] div_part;

  assign accept = start && (state_r == mmjd_pkg::ST_IDLE);
  assign busy   = (state_r != mmjd_pkg::ST_IDLE);

  assign zero_a   = ~|{in_word.first_x, in_word.first_y, in_word.first_z};
  assign zero_b   = ~|{in_word.second_x, in_word.second_y, in_word.second_z};
  assign in_range = pidx_r < PIDX_W'(mmjd_pkg::MAX_JOINTS);

  // one square a cycle, registered before accumulation
  always_comb begin
    case (step_r[1:0])
      2'd0:    mul_sel = dx_r;
      2'd1:    mul_sel = dy_r;
      default: mul_sel = dz_r;
    endcase
  end
  assign mul_full = mul_sel * mul_sel;

  // shift-in word for the restoring divide
  assign div_part = {drem_r, quo_r[SUM_W-1]};

  // the compare-subtract unit serves sqrt steps and divide steps
  always_comb begin
    if (state_r == mmjd_pkg::ST_DIV) begin
      alu_a = SQ_W'(div_part);
      alu_b = SQ_W'(count_r);
    end else begin
      alu_a = rem_r;
      alu_b = root_r + bit_r;
    end
  end

  mmjd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(root_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pidx_nxt      = pidx_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    quo_nxt       = quo_r;
    drem_nxt      = drem_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    case (state_r)
      mmjd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_word.kind) begin
            // empty skeleton: sentinel now, drop the set
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{mean_distance: mmjd_pkg::SENTINEL_Q16, no_overlap: 1'b1};
            pidx_nxt      = '0;
            sum_nxt       = '0;
            count_nxt     = '0;
          end else begin
            if (in_range) begin
              pidx_nxt = pidx_r + PIDX_W'(1);
            end
            if (in_range && !zero_a && !zero_b) begin
              dx_nxt    = DIFF_W'(in_word.first_x) - DIFF_W'(in_word.second_x);
              dy_nxt    = DIFF_W'(in_word.first_y) - DIFF_W'(in_word.second_y);
              dz_nxt    = DIFF_W'(in_word.first_z) - DIFF_W'(in_word.second_z);
              rem_nxt   = '0;
              step_nxt  = '0;
              last_nxt  = in_word.last_joint;
              state_nxt = mmjd_pkg::ST_MUL;
            end else if (in_word.last_joint) begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = '{mean_distance: mmjd_pkg::SENTINEL_Q16, no_overlap: 1'b1};
                pidx_nxt      = '0;
                sum_nxt       = '0;
                count_nxt     = '0;
              end else begin
                quo_nxt   = sum_r;
                drem_nxt  = '0;
                step_nxt  = '0;
                state_nxt = mmjd_pkg::ST_DIV;
              end
            end
          end
        end
      end

      mmjd_pkg::ST_MUL: begin
        // squares in steps 0..2; the sum takes each square from the product register, so it lags the product
        prod_nxt = mul_full[SQ_W-2:0];
        if (step_r != '0) begin
          rem_nxt = rem_r + {1'b0, prod_r};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd3) begin
          root_nxt  = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 2);
          state_nxt = mmjd_pkg::ST_SQRT;
        end
      end

      mmjd_pkg::ST_SQRT: begin
        // one root bit per place of two radicand bits, one place per cycle
        if (alu_res.ge) begin
          rem_nxt  = alu_res.diff;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = mmjd_pkg::ST_ACC;
        end
      end

      mmjd_pkg::ST_ACC: begin
        // saturating sum and count
        sum_nxt   = sum_wide[SUM_W] ? mmjd_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
        count_nxt = (count_r == mmjd_pkg::COUNT_MAX) ? count_r : count_r + CNT_W'(1);
        if (last_r) begin
          quo_nxt   = sum_nxt;
          drem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = mmjd_pkg::ST_DIV;
        end else begin
          state_nxt = mmjd_pkg::ST_IDLE;
        end
      end

      mmjd_pkg::ST_DIV: begin
        // restoring divide, one quotient bit a cycle
        drem_nxt = alu_res.ge ? alu_res.diff[CNT_W-1:0] : div_part[CNT_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], alu_res.ge};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{mean_distance: quo_nxt[mmjd_pkg::MEAN_W-1:0], no_overlap: 1'b0};
          pidx_nxt      = '0;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = mmjd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mmjd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmjd_pkg::ST_IDLE;
      step_r      <= '0;
      pidx_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pidx_r      <= pidx_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    quo_r      <= quo_nxt;
    drem_r     <= drem_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the masked mean joint distance top level
module tb_top;

  // package names used here
  localparam int COORD_W    = mmjd_pkg::COORD_W;
  localparam int SUM_W      = mmjd_pkg::SUM_W;
  localparam int CNT_W      = mmjd_pkg::CNT_W;
  localparam int MEAN_W     = mmjd_pkg::MEAN_W;
  localparam int MAX_JOINTS = mmjd_pkg::MAX_JOINTS;
  localparam logic [MEAN_W-1:0] SENTINEL_Q16 = mmjd_pkg::SENTINEL_Q16;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = mmjd_pkg::COUNT_MAX;
  localparam logic [SUM_W-1:0]  SUM_MAX      = mmjd_pkg::SUM_MAX;

  typedef mmjd_pkg::in_t  in_t;
  typedef mmjd_pkg::out_t out_t;

  // word kinds carried in in_word.kind
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_EMPTY = 1'b1;

  // run shape: random words, quiet tail with no idling, drain window, cycle limit
  localparam int RANDOM_WORDS = 550;
  localparam int CALM_TAIL    = 60;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 600_000;

  // handy Q8.16 coordinates
  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] ONE_Q = 24'sd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // one line of the directed table; want is used only when typed is set
  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_word;
  logic out_valid;
  out_t out_word;

  masked_mean_joint_distance_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // running state of the set, mirrored from the block's behavior
  logic [SUM_W-1:0] joint_sum;
  logic [CNT_W-1:0] joint_count;
  int               joint_pos;

  // means still owed by the block, oldest first
  out_t expected_means[$];

  int  mismatches;
  int  words_sent;
  int  results_checked;
  int  sentinel_results;
  int  cycle_count;
  bit  idle_on;
  bit  calm_tail;
  row_t directed_rows[$];

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_set();
    joint_sum   = '0;
    joint_count = '0;
    joint_pos   = 0;
  endtask

  // bit-by-bit floor square root, enough for the 50-bit squared span
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // advance the set state by one word; fires when the word closes a set
  task automatic predict_mean(input in_t w, output bit fires, output out_t res);
    longint      dx;
    longint      dy;
    longint      dz;
    logic [63:0] sq;
    logic [63:0] total;
    bit          a_zero;
    bit          b_zero;
    fires = 1'b0;
    res   = '0;
    // empty skeleton: sentinel at once, gathered pairs thrown away
    if (w.kind == KIND_EMPTY) begin
      fires = 1'b1;
      res.mean_distance = SENTINEL_Q16;
      res.no_overlap    = 1'b1;
      clear_set();
      return;
    end
    // pairs past the joint window are neither accumulated nor counted as position
    if (joint_pos < MAX_JOINTS) begin
      a_zero = (w.first_x == 0) && (w.first_y == 0) && (w.first_z == 0);
      b_zero = (w.second_x == 0) && (w.second_y == 0) && (w.second_z == 0);
      if (!a_zero && !b_zero) begin
        dx = longint'(w.first_x) - longint'(w.second_x);
        dy = longint'(w.first_y) - longint'(w.second_y);
        dz = longint'(w.first_z) - longint'(w.second_z);
        sq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
        total = 64'(joint_sum) + 64'(floor_sqrt(sq));
        // sum and count both saturate
        joint_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
        if (joint_count != COUNT_MAX) joint_count++;
      end
      joint_pos++;
    end
    if (!w.last_joint) return;
    fires = 1'b1;
    if (joint_count == 0) begin
      res.mean_distance = SENTINEL_Q16;
      res.no_overlap    = 1'b1;
    end else begin
      res.mean_distance = MEAN_W'(joint_sum / SUM_W'(joint_count));
      res.no_overlap    = 1'b0;
    end
    clear_set();
  endtask

  // idle bursts come and go in phases; none at all in the tail
  function automatic int next_gap();
    if (calm_tail) return 0;
    if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
    if (idle_on && $urandom_range(0, 2) == 0) return $urandom_range(1, 13);
    return 0;
  endfunction

  // present one word at the falling edge and hold it until start meets busy low
  task automatic send_word(input in_t w, input bit typed, input out_t want, input int gap);
    bit   fires;
    out_t res;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    // word taken at this edge
    predict_mean(w, fires, res);
    if (fires) expected_means.push_back(typed ? want : res);
    words_sent++;
  endtask

  function automatic row_t mk(input logic kind,
                              input logic signed [COORD_W-1:0] ax, ay, az,
                              input logic signed [COORD_W-1:0] bx, by, bz,
                              input logic last, input bit typed = 1'b0,
                              input logic [MEAN_W-1:0] mean = '0, input logic flag = 1'b0);
    row_t r;
    r.word.kind       = kind;
    r.word.first_x    = ax;
    r.word.first_y    = ay;
    r.word.first_z    = az;
    r.word.second_x   = bx;
    r.word.second_y   = by;
    r.word.second_z   = bz;
    r.word.last_joint = last;
    r.typed              = typed;
    r.want.mean_distance = mean;
    r.want.no_overlap    = flag;
    return r;
  endfunction

  // coordinate styles: full range, small magnitude, or an extreme value
  function automatic logic signed [COORD_W-1:0] random_coord(input int style);
    case (style)
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 2047)) - 24'sd1024;
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return 24'sd1;
          default: return -24'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic point_t random_point();
    int     pick;
    int     style;
    point_t p;
    pick = $urandom_range(0, 9);
    // one in ten is the zero vector, a masked joint
    if (pick == 0) return '0;
    style = (pick < 5) ? 0 : ((pick < 8) ? 1 : 2);
    p.x = random_coord(style);
    p.y = random_coord(style);
    p.z = random_coord(style);
    return p;
  endfunction

  // result checker: every strobe must match the oldest owed mean
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_means.size() == 0) begin
        note_mismatch($sformatf("result with none owed: mean %0d flag %0b",
                                out_word.mean_distance, out_word.no_overlap));
      end else begin
        want = expected_means.pop_front();
        results_checked++;
        if (want.no_overlap) sentinel_results++;
        if (out_word.mean_distance !== want.mean_distance)
          note_mismatch($sformatf("mean_distance %0d, want %0d",
                                  out_word.mean_distance, want.mean_distance));
        if (out_word.no_overlap !== want.no_overlap)
          note_mismatch($sformatf("no_overlap %0b, want %0b",
                                  out_word.no_overlap, want.no_overlap));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d means still owed",
               cycle_count, expected_means.size());
      $display("[masked_mean_joint_distance_top] ERROR");
      $finish;
    end
  end

  initial begin
    in_t    w;
    point_t a;
    point_t b;
    int     set_len;
    int     set_no;
    int     random_sent;
    int     pick;
    bit     paused;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    mismatches       = 0;
    words_sent       = 0;
    results_checked  = 0;
    sentinel_results = 0;
    cycle_count      = 0;
    idle_on          = 1'b1;
    calm_tail        = 1'b0;
    paused           = 1'b0;
    clear_set();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words: masks, extremes, window reset by an empty skeleton
    directed_rows = '{
      // empty skeleton right after reset, then one flagged last
      mk(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, SENTINEL_Q16, 1'b1),
      mk(KIND_EMPTY, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1,
         SENTINEL_Q16, 1'b1),
      // single masked pair closes a set with nothing counted
      mk(KIND_PAIR, 0, 0, 0, ONE_Q, 0, 0, 1'b1, 1'b1, SENTINEL_Q16, 1'b1),
      mk(KIND_PAIR, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1'b1, 1'b1, SENTINEL_Q16, 1'b1),
      mk(KIND_PAIR, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, SENTINEL_Q16, 1'b1),
      // unit axes
      mk(KIND_PAIR, ONE_Q, 0, 0, 0, ONE_Q, 0, 1'b1),
      // full-scale opposite corners
      mk(KIND_PAIR, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b1),
      // three-pair set mixing corners and single-lsb points
      mk(KIND_PAIR, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0),
      mk(KIND_PAIR, 24'sd1, 0, 0, 0, 0, 24'sd1, 1'b0),
      mk(KIND_PAIR, -24'sd1, -24'sd1, -24'sd1, ONE_Q, -ONE_Q, 0, 1'b1),
      // coincident points: distance zero yet counted
      mk(KIND_PAIR, 24'sd123456, -24'sd7, ONE_Q, 24'sd123456, -24'sd7, ONE_Q, 1'b1,
         1'b1, '0, 1'b0),
      // masked pair inside a set is skipped
      mk(KIND_PAIR, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, -ONE_Q, 0, ONE_Q, 1'b0),
      mk(KIND_PAIR, 0, 0, 0, C_MIN, 0, C_MAX, 1'b0),
      mk(KIND_PAIR, 0, 0, ONE_Q, 0, 0, -ONE_Q, 1'b1),
      // pairs gathered, then an empty skeleton throws them away
      mk(KIND_PAIR, ONE_Q, ONE_Q, 0, -ONE_Q, 0, C_MAX, 1'b0),
      mk(KIND_PAIR, C_MAX, 0, C_MIN, 24'sd5, 24'sd9, -24'sd3, 1'b0),
      mk(KIND_EMPTY, 24'sd77, -24'sd1, C_MIN, ONE_Q, C_MAX, 24'sd3, 1'b0, 1'b1,
         SENTINEL_Q16, 1'b1),
      // fresh set afterwards: distance 2.0
      mk(KIND_PAIR, 0, 0, ONE_Q, 0, 0, -ONE_Q, 1'b1, 1'b1, 30'd131072, 1'b0),
      mk(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, SENTINEL_Q16, 1'b1),
      // widest single-axis span
      mk(KIND_PAIR, C_MAX, 0, 0, C_MIN, 0, 0, 1'b1, 1'b1, 30'd16777215, 1'b0),
      // a set made only of masked pairs
      mk(KIND_PAIR, 0, 0, 0, 0, 0, 0, 1'b0),
      mk(KIND_PAIR, 0, 0, 0, C_MAX, C_MIN, 24'sd1, 1'b1, 1'b1, SENTINEL_Q16, 1'b1)
    };
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want,
                next_gap());

    // random sets: mostly short well-formed runs, a few that overrun the window,
    // with stray empty-skeleton words breaking sets now and then
    set_no      = 0;
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 49);
      if (set_no == 6 || set_no == 45 || pick == 0) set_len = $urandom_range(65, 72);
      else if (pick < 6) set_len = $urandom_range(9, 20);
      else set_len = $urandom_range(1, 8);

      for (int j = 0; j < set_len; j++) begin
        calm_tail = (random_sent >= RANDOM_WORDS - CALM_TAIL);

        // once, halfway, hold the sender off until every owed mean is back
        if (!paused && random_sent >= RANDOM_WORDS / 2) begin
          paused = 1'b1;
          @(negedge clk);
          start <= 1'b0;
          while (expected_means.size() != 0) @(posedge clk);
        end

        if ($urandom_range(0, 39) == 0) begin
          // stray empty skeleton with junk coordinates ends the set early
          w.kind       = KIND_EMPTY;
          w.first_x    = COORD_W'($urandom);
          w.first_y    = COORD_W'($urandom);
          w.first_z    = COORD_W'($urandom);
          w.second_x   = COORD_W'($urandom);
          w.second_y   = COORD_W'($urandom);
          w.second_z   = COORD_W'($urandom);
          w.last_joint = 1'($urandom_range(0, 1));
          send_word(w, 1'b0, '0, next_gap());
          random_sent++;
          break;
        end

        a = random_point();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          b = a;
        end else if (pick < 3) begin
          // near miss around the first joint
          b.x = a.x + random_coord(1);
          b.y = a.y + random_coord(1);
          b.z = a.z + random_coord(1);
        end else begin
          b = random_point();
        end

        w.kind       = KIND_PAIR;
        w.first_x    = a.x;
        w.first_y    = a.y;
        w.first_z    = a.z;
        w.second_x   = b.x;
        w.second_y   = b.y;
        w.second_z   = b.z;
        w.last_joint = (j == set_len - 1);
        send_word(w, 1'b0, '0, next_gap());
        random_sent++;
      end
      set_no++;
    end

    @(negedge clk);
    start <= 1'b0;

    // collect what is owed, then watch a while for strays
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d random sets plus %0d directed, %0d means checked",
             words_sent, set_no, directed_rows.size(), results_checked);
    $display("%0d sentinel results; long sets ran past the %0d-joint window",
             sentinel_results, MAX_JOINTS);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("[masked_mean_joint_distance_top] OK");
    end else begin
      $display("[masked_mean_joint_distance_top] ERROR");
    end
    $finish;
  end

endmodule
